FILE: hdl/njls_pkg.sv
package njls_pkg;

    localparam int ID_W   = 8;
    localparam int SVC_W  = 16;
    localparam int TIME_W = 32;

    // Item action codes
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // One stored job
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SVC_W-1:0]  svc;
        logic [TIME_W-1:0] arr;
    } t_slot;

    // Insertion wavefront handed from cell to cell
    typedef struct packed {
        logic  tok;
        logic  placed;
        t_slot job;
    } t_carry;

    // Shared control seen by every cell
    typedef struct packed {
        logic shift_left;
        logic longest_first;
    } t_cell_ctrl;

    // Result payload, bar the queue occupancy
    typedef struct packed {
        logic              accepted;
        logic              busy;
        logic [ID_W-1:0]   running_id;
        logic              done;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } t_res;

    // True when new key k must sit ahead of stored key e
    function automatic logic goes_before(logic [SVC_W-1:0] k, logic [SVC_W-1:0] e,
                                         logic lf);
        logic r;
        r = lf ? (k > e) : (k < e);
        return r;
    endfunction

endpackage

FILE: hdl/njls_if.sv
interface njls_job_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [njls_pkg::ID_W-1:0]   job_id;
    logic [njls_pkg::SVC_W-1:0]  service_time;

    modport source (output valid, action, job_id, service_time, input ready);
    modport sink   (input valid, action, job_id, service_time, output ready);
endinterface

interface njls_res_if #(parameter int CNT_W = 5);
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        busy_res;
    logic [njls_pkg::ID_W-1:0]   running_id;
    logic                        done_res;
    logic [njls_pkg::TIME_W-1:0] finish_time;
    logic [njls_pkg::TIME_W-1:0] turnaround;
    logic [njls_pkg::TIME_W-1:0] waiting;
    logic [CNT_W-1:0]            queued_jobs;

    modport source (output valid, accepted, busy_res, running_id, done_res, finish_time,
                    turnaround, waiting, queued_jobs, input ready);
    modport sink   (input valid, accepted, busy_res, running_id, done_res, finish_time,
                    turnaround, waiting, queued_jobs, output ready);
endinterface

interface njls_cfg_if;
    logic valid;
    logic ready;
    logic longest_first;

    modport source (output valid, longest_first, input ready);
    modport sink   (input valid, longest_first, output ready);
endinterface

FILE: hdl/nonpreemptive_job_length_scheduler_core.sv
// Channel   Dir  Beat contents
// i_job     in   action, job_id, service_time
// o_res     out  accepted, busy_res, running_id, done_res, finish_time,
//                turnaround, waiting, queued_jobs
// i_cfg     in   longest_first (always ready)
//
// A tick or a rejected arrival is finished in S_IDLE. An accepted arrival
// holds the core in S_WAVE while the insertion wavefront walks the cell row
// one cell per cycle from the head to the first empty slot.
// Reset clears occupancy, time and head remaining; slot contents are left as is.
// The result register lets a new beat enter while the last result is still
// waiting, provided it is taken in the same cycle.
module nonpreemptive_job_length_scheduler_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    njls_job_if.sink    i_job,
    njls_cfg_if.sink    i_cfg,
    njls_res_if.source  o_res
);
    import njls_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    typedef enum logic {S_IDLE, S_WAVE} t_state;

    t_state            r_state, n_state;
    logic              r_lf;
    logic [CW-1:0]     r_count, n_count;
    logic [SVC_W-1:0]  r_head_rem, n_head_rem;
    logic [TIME_W-1:0] r_now, n_now;
    logic [IW-1:0]     r_wave_left, n_wave_left;
    t_carry            r_inj, n_inj;
    logic              r_out_valid, n_out_valid;
    t_res              r_res, n_res;
    logic [CW-1:0]     r_q_jobs, n_q_jobs;

    t_slot             w_slot  [QUEUE_DEPTH];
    t_carry            w_carry [QUEUE_DEPTH+1];
    t_cell_ctrl        cell_ctrl;

    logic              job_acc;
    logic              arr_ok;
    logic [TIME_W-1:0] now_inc;
    logic [SVC_W-1:0]  rem_dec;
    logic              head_done;
    logic [TIME_W-1:0] turn;

    assign job_acc   = i_job.valid && i_job.ready;
    assign arr_ok    = (i_job.service_time != '0) && (r_count < CW'(QUEUE_DEPTH));
    assign now_inc   = r_now + 1'b1;
    assign rem_dec   = r_head_rem - 1'b1;
    assign head_done = (r_count != '0) && (rem_dec == '0);
    assign turn      = now_inc - w_slot[0].arr;

    assign i_job.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign i_cfg.ready = 1'b1;

    assign cell_ctrl.shift_left    = job_acc && (i_job.action == ACT_TICK) && head_done;
    assign cell_ctrl.longest_first = r_lf;

    // Row of cells, head at index 0
    assign w_carry[0] = r_inj;
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot right;
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right = w_slot[g];
        end else begin : g_mid
            assign right = w_slot[g+1];
        end
        njls_cell #(.IDX(g), .CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_count (r_count),
            .i_carry (w_carry[g]),
            .i_right (right),
            .o_carry (w_carry[g+1]),
            .o_slot  (w_slot[g])
        );
    end

    // Next-state and result logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head_rem  = r_head_rem;
        n_now       = r_now;
        n_wave_left = r_wave_left;
        n_inj       = r_inj;
        n_inj.tok   = 1'b0;
        n_out_valid = r_out_valid && !o_res.ready;
        n_res       = r_res;
        n_q_jobs    = r_q_jobs;

        case (r_state)
            S_IDLE: begin
                if (job_acc) begin
                    n_out_valid = 1'b1;
                    n_res       = '0;
                    n_q_jobs    = r_count;
                    if (i_job.action == ACT_ARRIVE) begin
                        if (arr_ok) begin
                            n_res.accepted = 1'b1;
                            n_q_jobs       = r_count + 1'b1;
                            n_inj.tok      = 1'b1;
                            n_inj.placed   = 1'b0;
                            n_inj.job.id   = i_job.job_id;
                            n_inj.job.svc  = i_job.service_time;
                            n_inj.job.arr  = r_now;
                            n_wave_left    = r_count[IW-1:0];
                            n_state        = S_WAVE;
                            if (r_count == '0) begin
                                n_head_rem = i_job.service_time;
                            end
                        end
                    end else begin
                        n_now = now_inc;
                        if (r_count != '0) begin
                            n_res.busy       = 1'b1;
                            n_res.running_id = w_slot[0].id;
                            n_head_rem       = rem_dec;
                            if (head_done) begin
                                n_res.done        = 1'b1;
                                n_res.finish_time = now_inc;
                                n_res.turnaround  = turn;
                                n_res.waiting     = turn - TIME_W'(w_slot[0].svc);
                                n_count           = r_count - 1'b1;
                                n_q_jobs          = r_count - 1'b1;
                                n_head_rem        = w_slot[1].svc;
                            end
                        end
                    end
                end
            end
            S_WAVE: begin
                // Hold until the wavefront has reached the first free slot
                n_wave_left = r_wave_left - 1'b1;
                if (r_wave_left == '0) begin
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wave_left <= n_wave_left;
        r_res       <= n_res;
        r_q_jobs    <= n_q_jobs;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_now       <= '0;
            r_head_rem  <= '0;
            r_out_valid <= 1'b0;
            r_inj       <= '0;
            r_lf        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_now       <= n_now;
            r_head_rem  <= n_head_rem;
            r_out_valid <= n_out_valid;
            r_inj       <= n_inj;
            if (i_cfg.valid && i_cfg.ready) begin
                r_lf <= i_cfg.longest_first;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.accepted    = r_res.accepted;
    assign o_res.busy_res    = r_res.busy;
    assign o_res.running_id  = r_res.running_id;
    assign o_res.done_res    = r_res.done;
    assign o_res.finish_time = r_res.finish_time;
    assign o_res.turnaround  = r_res.turnaround;
    assign o_res.waiting     = r_res.waiting;
    assign o_res.queued_jobs = r_q_jobs;

    // The wavefront always lands before running off the end of the row
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_carry[QUEUE_DEPTH].tok)
        else $error("insertion wavefront left the cell row");

    // Occupancy never exceeds the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    // A completing tick drops the occupancy by one
    a_done_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctrl.shift_left |=> (r_count == $past(r_count) - 1'b1))
        else $error("completion did not pop the head");

    // No new beat is taken while an insertion is in flight
    a_wave_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAVE) |-> !i_job.ready)
        else $error("input taken during insertion");

endmodule

FILE: hdl/njls_cell.sv
module njls_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  njls_pkg::t_cell_ctrl i_ctrl,
    input  logic [CW-1:0]        i_count,
    input  njls_pkg::t_carry     i_carry,
    input  njls_pkg::t_slot      i_right,
    output njls_pkg::t_carry     o_carry,
    output njls_pkg::t_slot      o_slot
);
    import njls_pkg::*;

    t_slot  r_slot,  n_slot;
    t_carry r_carry, n_carry;
    logic   live;
    logic   ahead;
    logic   take;

    // Slot holds a job when its index lies below the occupancy
    assign live   = CW'(IDX) < i_count;
    // The head slot is never displaced
    assign ahead  = (IDX != 0) && goes_before(i_carry.job.svc, r_slot.svc,
                                              i_ctrl.longest_first);
    assign take   = i_carry.tok && (!live || i_carry.placed || ahead);

    // Shift left on completion, else swap with the passing wavefront
    always_comb begin
        n_slot         = r_slot;
        n_carry.tok    = i_carry.tok && live && !i_ctrl.shift_left;
        n_carry.placed = i_carry.placed || ahead;
        n_carry.job    = (i_carry.placed || ahead) ? r_slot : i_carry.job;
        if (i_ctrl.shift_left) begin
            n_slot = i_right;
        end else if (take) begin
            n_slot = i_carry.job;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;
    assign o_slot  = r_slot;

endmodule
